>>> rtl/core/tisp_pkg.sv
// Package for the typed integer sum parser: phase enum, status codes,
// kind helpers. No dependencies.
package tisp_pkg;

    typedef enum logic [2:0] {
        PH_TERM_START,
        PH_AFTER_MINUS,
        PH_DIGITS,
        PH_SUFFIX,
        PH_AFTER_TERM,
        PH_ERROR
    } t_phase;

    typedef enum logic [2:0] {
        SP_NONE   = 3'd0,
        SP_LETTER = 3'd1,
        SP_WANT6  = 3'd2,
        SP_WANT2  = 3'd3,
        SP_WANT4  = 3'd4,
        SP_DONE   = 3'd5
    } t_sprog;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_EXPECTED = 3'd2;
    localparam logic [2:0] ST_DIGITS   = 3'd3;
    localparam logic [2:0] ST_SUFFIX   = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;
    localparam logic [2:0] ST_OPERATOR = 3'd6;

    function automatic logic [63:0] umax(input logic [1:0] w);
        unique case (w)
            2'd0: umax = 64'hFF;
            2'd1: umax = 64'hFFFF;
            2'd2: umax = 64'hFFFF_FFFF;
            default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic logic [63:0] smax(input logic [1:0] w);
        smax = umax(w) >> 1;
    endfunction

    function automatic logic [2:0] promote(input logic [2:0] a, input logic [2:0] b);
        logic [2:0] u;
        logic [2:0] s;
        u = a[2] ? b : a;
        s = a[2] ? a : b;
        if (a == b) promote = a;
        else if (a[2] == b[2]) promote = (a[1:0] > b[1:0]) ? a : b;
        else promote = (u[1:0] >= s[1:0]) ? u : s;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        is_dig = (c >= 8'd48) && (c <= 8'd57);
    endfunction

endpackage

>>> rtl/core/typed_integer_sum_parser.sv
// Typed integer sum parser: one character per word, one result per zero byte.
// A result is registered in the cycle after the zero byte is accepted.
// Throughput: one character per cycle unless an unread result stalls the input;
// the digit step (times ten plus digit) and term add/range check fit in that cycle.
// Reset: synchronous active low, returns to the start of an expression.
// Depends on tisp_pkg.
module typed_integer_sum_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] char_code
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // [2:0] status, [66:3] unsigned_sum,
                                         // [130:67] signed_sum, [131] sum_is_unsigned
);
    import tisp_pkg::*;

    t_phase      r_phase, n_phase;
    t_sprog      r_sp, n_sp;
    logic [63:0] r_acc, n_acc;
    logic        r_ovf, n_ovf;
    logic        r_neg, n_neg;
    logic [2:0]  r_tk, n_tk;
    logic [63:0] r_tot, n_tot;
    logic [2:0]  r_totk, n_totk;
    logic        r_first, n_first;
    logic [2:0]  r_err, n_err;
    logic        r_ov;
    logic [131:0] r_out;

    logic        take;
    logic [7:0]  c;
    logic [3:0]  d;
    logic [67:0] mul;
    logic [63:0] bits, usum, tlim;
    logic        ucarry, term_fail;
    logic [2:0]  term_code, pk;
    logic        sum_fail;
    logic [64:0] ssum;
    logic [63:0] smx;
    logic [2:0]  fst;
    logic [63:0] fin_tot;
    logic [2:0]  fin_tk;

    assign s_axis_tready = !r_ov || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign c = s_axis_tdata;
    assign d = c[3:0] - 4'd0;
    assign mul = {4'd0, r_acc} * 68'd10 + {64'd0, d};

    // term completion checks, sum range check and next total
    always_comb begin
        tlim = smax(r_tk[1:0]) + {63'd0, r_neg};
        bits = (r_tk[2] && r_neg) ? (64'd0 - r_acc) : r_acc;
        term_fail = 1'b0;
        term_code = ST_RANGE;
        if (!r_tk[2] && r_neg) begin
            term_fail = 1'b1; term_code = ST_DIGITS;
        end else if (r_ovf) term_fail = 1'b1;
        else if (!r_tk[2] && r_acc > umax(r_tk[1:0])) term_fail = 1'b1;
        else if (r_tk[2] && r_acc > tlim) term_fail = 1'b1;
        pk = promote(r_totk, r_tk);
        {ucarry, usum} = {1'b0, r_tot} + {1'b0, bits};
        ssum = {r_tot[63], r_tot} + {bits[63], bits};
        smx = smax(pk[1:0]);
        if (!pk[2]) sum_fail = ucarry || (usum > umax(pk[1:0]));
        else sum_fail = ($signed(ssum) > $signed({1'b0, smx})) ||
                        ($signed(ssum) < $signed(~{1'b0, smx}));
        fin_tot = r_first ? bits : usum;
        fin_tk  = r_first ? r_tk : pk;
    end

    always_comb begin
        n_phase = r_phase; n_sp = r_sp; n_acc = r_acc; n_ovf = r_ovf;
        n_neg = r_neg; n_tk = r_tk; n_tot = r_tot; n_totk = r_totk;
        n_first = r_first; n_err = r_err;
        fst = ST_OK;
        unique case (r_phase)
            PH_TERM_START: begin
                if (c == 8'd0) fst = r_first ? ST_EMPTY : ST_EXPECTED;
                else if (is_ws(c)) ;
                else if (c == 8'h2D) begin n_neg = 1'b1; n_phase = PH_AFTER_MINUS; end
                else if (is_dig(c)) begin
                    n_acc = {60'd0, d}; n_ovf = 1'b0; n_phase = PH_DIGITS;
                end else fst = (c == 8'h2B) ? ST_EXPECTED : ST_DIGITS;
            end
            PH_AFTER_MINUS: begin
                if (is_dig(c)) begin
                    n_acc = {60'd0, d}; n_ovf = 1'b0; n_phase = PH_DIGITS;
                end else fst = (c == 8'd0 || c == 8'h2B) ? ST_EXPECTED : ST_DIGITS;
            end
            PH_DIGITS: begin
                if (is_dig(c)) begin
                    if (mul[67:64] != 4'd0) n_ovf = 1'b1;
                    n_acc = mul[63:0];
                end else if (c == 8'h55 || c == 8'h49) begin
                    n_tk = (c == 8'h55) ? 3'd0 : 3'd4;
                    n_sp = SP_LETTER; n_phase = PH_SUFFIX;
                end else if (c == 8'd0 || c == 8'h75 || c == 8'h69 || c == 8'h2B ||
                             is_ws(c) || (c >= 8'h41 && c <= 8'h5A)) fst = ST_SUFFIX;
                else fst = ST_DIGITS;
            end
            PH_SUFFIX: begin
                unique case (r_sp)
                    SP_LETTER: begin
                        if (c == 8'h38) n_sp = SP_DONE;
                        else if (c == 8'h31) n_sp = SP_WANT6;
                        else if (c == 8'h33) n_sp = SP_WANT2;
                        else if (c == 8'h36) n_sp = SP_WANT4;
                        else fst = ST_SUFFIX;
                    end
                    SP_WANT6: if (c == 8'h36) begin n_tk = r_tk | 3'd1; n_sp = SP_DONE; end
                              else fst = ST_SUFFIX;
                    SP_WANT2: if (c == 8'h32) begin n_tk = r_tk | 3'd2; n_sp = SP_DONE; end
                              else fst = ST_SUFFIX;
                    SP_WANT4: if (c == 8'h34) begin n_tk = r_tk | 3'd3; n_sp = SP_DONE; end
                              else fst = ST_SUFFIX;
                    SP_DONE: begin
                        if (c != 8'd0 && c != 8'h2B && !is_ws(c)) fst = ST_SUFFIX;
                        else if (term_fail) fst = term_code;
                        else if (!r_first && sum_fail) fst = ST_RANGE;
                        else begin
                            n_tot = fin_tot; n_totk = fin_tk; n_first = 1'b0;
                            n_neg = 1'b0; n_sp = SP_NONE;
                            n_phase = (c == 8'h2B) ? PH_TERM_START : PH_AFTER_TERM;
                        end
                    end
                    default: fst = ST_SUFFIX;
                endcase
            end
            PH_AFTER_TERM: begin
                if (c == 8'h2B) n_phase = PH_TERM_START;
                else if (c != 8'd0 && !is_ws(c)) fst = ST_OPERATOR;
            end
            default: ;
        endcase
        if (fst != ST_OK) begin n_err = fst; n_phase = PH_ERROR; end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TERM_START; r_sp <= SP_NONE; r_acc <= '0; r_ovf <= 1'b0;
            r_neg <= 1'b0; r_tk <= '0; r_tot <= '0; r_totk <= '0;
            r_first <= 1'b1; r_err <= ST_OK; r_ov <= 1'b0;
        end else begin
            if (m_axis_tready && !(take && c == 8'd0)) r_ov <= 1'b0;
            if (take) begin
                if (c == 8'd0) begin
                    // emit and restart the expression
                    r_ov <= 1'b1;
                    if (n_err != ST_OK || n_first)
                        r_out <= {1'b0, 64'd0, 64'd0, (n_err != ST_OK) ? n_err : ST_EMPTY};
                    else
                        r_out <= {!n_totk[2], n_tot, n_tot, ST_OK};
                    r_phase <= PH_TERM_START; r_sp <= SP_NONE; r_acc <= '0;
                    r_ovf <= 1'b0; r_neg <= 1'b0; r_tk <= '0; r_tot <= '0;
                    r_totk <= '0; r_first <= 1'b1; r_err <= ST_OK;
                end else begin
                    r_phase <= n_phase; r_sp <= n_sp; r_acc <= n_acc; r_ovf <= n_ovf;
                    r_neg <= n_neg; r_tk <= n_tk; r_tot <= n_tot; r_totk <= n_totk;
                    r_first <= n_first; r_err <= n_err;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {4'd0, r_out};

`ifndef ASSERT_OFF
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) |-> (r_phase == PH_ERROR)) else $error("error without phase");
    a_ok_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out[2:0] != ST_OK) |-> (r_out[131:3] == '0)) else $error("nonzero on err");
    a_zero_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && c == 8'd0) |=> r_ov) else $error("no result");
    a_first_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> (r_tot == '0)) else $error("total before term");
`endif
endmodule
